[rtl/core/tmrs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmrs_pkg
// shared types and constants of the tile marker rectangle scan block
// ----------------------------------------------------------------------------
package tmrs_pkg;

    localparam int COLOR_W  = 8;
    localparam int TILE_W   = 7;
    localparam int POS_OUT_W  = 6;
    localparam int SIZE_OUT_W = 7;

    localparam logic [COLOR_W-1:0] MARKER_FULL     = 8'hFF;
    localparam logic [COLOR_W-1:0] MARKER_NONE     = 8'h00;
    localparam logic [TILE_W-1:0]  TILE_SIZE_RESET = 7'd16;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [POS_OUT_W-1:0]  left_x;
        logic [POS_OUT_W-1:0]  bottom_y;
        logic [SIZE_OUT_W-1:0] rect_width;
        logic [SIZE_OUT_W-1:0] rect_height;
        logic                  is_blocking;
    } rect_t;

endpackage

[rtl/core/tile_marker_rect_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_marker_rect_scan
// marker rectangle scan over the pixels of one square tile
// ----------------------------------------------------------------------------
// Pixels of a square tile enter in raster order, one per cycle, and the block
// keeps its own column and row count from tile_size. Each pixel goes through an
// input register and then one pass of compare and subtract logic that updates
// the marker state; a tile's last pixel loads the rectangle into the result
// register. Sustained rate is one pixel per cycle, set by the single scan
// stage; a stalled result holds the scan stage and then the input. The user
// writes tile_size while no pixel is in flight; the block does not check it.
// ----------------------------------------------------------------------------
module tile_marker_rect_scan
    import tmrs_pkg::*;
#(
    parameter int MAX_TILE = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [TILE_W-1:0] cfg_data,
    input  logic              pixel_valid,
    output logic              pixel_stall,
    input  pixel_t            pixel,
    output logic              rect_valid,
    input  logic              rect_stall,
    output rect_t             rect
);

    logic [TILE_W-1:0] tile_size_reg;
    logic [TILE_W-1:0] tile_size_next;
    logic              held_valid;
    pixel_t            held_pixel;
    logic              advance;
    logic              slot_free;
    logic              tile_done;
    logic              load;
    rect_t             scan_rect;

    assign tile_size_next = cfg_write ? cfg_data : tile_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tile_size_reg <= TILE_SIZE_RESET;
        else
            tile_size_reg <= tile_size_next;
    end

    // the scan stage moves only when a finished tile can enter the result slot
    assign advance = held_valid && slot_free;
    assign load    = advance && tile_done;

    tmrs_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .advance     (advance),
        .held_valid  (held_valid),
        .held_pixel  (held_pixel)
    );

    tmrs_scan #(
        .MAX_TILE (MAX_TILE)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .pix       (held_pixel),
        .tile_size (tile_size_reg),
        .tile_done (tile_done),
        .rect      (scan_rect)
    );

    tmrs_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .load_rect  (scan_rect),
        .slot_free  (slot_free),
        .rect_valid (rect_valid),
        .rect_stall (rect_stall),
        .rect       (rect)
    );

    // a result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !rect_valid || !rect_stall)
        else $error("result register overwritten");

    // the input is held back only by a full input register behind a busy result slot
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> held_valid && !slot_free)
        else $error("input stalled without a pending pixel");

endmodule

[rtl/core/tmrs_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmrs_in_stage
// input register: holds one pixel until the scan stage takes it
// ----------------------------------------------------------------------------
module tmrs_in_stage
    import tmrs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   pixel_valid,
    output logic   pixel_stall,
    input  pixel_t pixel,
    input  logic   advance,
    output logic   held_valid,
    output pixel_t held_pixel
);

    logic   valid_reg;
    logic   valid_next;
    pixel_t pix_reg;
    logic   accept;

    assign pixel_stall = valid_reg && !advance;
    assign accept      = pixel_valid && !pixel_stall;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            pix_reg <= pixel;
    end

    assign held_valid = valid_reg;
    assign held_pixel = pix_reg;

endmodule

[rtl/core/tmrs_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmrs_scan
// raster position counters, marker tracking and rectangle result logic
// ----------------------------------------------------------------------------
module tmrs_scan
    import tmrs_pkg::*;
#(
    parameter int MAX_TILE = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  pixel_t            pix,
    input  logic [TILE_W-1:0] tile_size,
    output logic              tile_done,
    output rect_t             rect
);

    localparam int POS_W  = (MAX_TILE > 1) ? $clog2(MAX_TILE) : 1;
    localparam int EDGE_W = $clog2(MAX_TILE + 1);
    localparam int CMP_W  = ((EDGE_W > TILE_W) ? EDGE_W : TILE_W) + 1;

    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] row_reg, row_next;
    logic [POS_W-1:0] first_col_reg, first_col_next;
    logic [POS_W-1:0] first_row_reg, first_row_next;
    logic [POS_W-1:0] last_col_reg, last_col_next;
    logic [POS_W-1:0] last_row_reg, last_row_next;
    logic             seen_reg, seen_next;
    logic             blocking_reg, blocking_next;

    logic [POS_W-1:0] first_col_upd, first_row_upd, last_col_upd, last_row_upd;
    logic             seen_upd, blocking_upd;
    logic             is_red, is_green, is_marker;
    logic [CMP_W-1:0] size_ext, max_ext, edge_len, col_inc, row_inc;
    logic             row_end;
    logic [CMP_W-1:0] fc_ext, fr_ext, lc_ext, lr_ext, w_ext, h_ext;

    assign is_red    = (pix.red == MARKER_FULL) && (pix.green == MARKER_NONE)
                       && (pix.blue == MARKER_NONE);
    assign is_green  = (pix.red == MARKER_NONE) && (pix.green == MARKER_FULL)
                       && (pix.blue == MARKER_NONE);
    assign is_marker = is_red || is_green;

    // clamp the edge length to 1..MAX_TILE
    assign size_ext = CMP_W'(tile_size);
    assign max_ext  = CMP_W'(MAX_TILE);
    always_comb
    begin
        if (size_ext == '0)
            edge_len = CMP_W'(1);
        else if (size_ext > max_ext)
            edge_len = max_ext;
        else
            edge_len = size_ext;
    end

    assign col_inc   = CMP_W'(col_reg) + CMP_W'(1);
    assign row_inc   = CMP_W'(row_reg) + CMP_W'(1);
    assign row_end   = (col_inc >= edge_len);
    assign tile_done = row_end && (row_inc >= edge_len);

    // marker state including the current pixel
    always_comb
    begin
        first_col_upd = first_col_reg;
        first_row_upd = first_row_reg;
        last_col_upd  = last_col_reg;
        last_row_upd  = last_row_reg;
        seen_upd      = seen_reg;
        blocking_upd  = blocking_reg && !is_green;
        if (is_marker)
        begin
            if (!seen_reg)
            begin
                first_col_upd = col_reg;
                first_row_upd = row_reg;
            end
            last_col_upd = col_reg;
            last_row_upd = row_reg;
            seen_upd     = 1'b1;
        end
    end

    assign fc_ext = CMP_W'(first_col_upd);
    assign fr_ext = CMP_W'(first_row_upd);
    assign lc_ext = CMP_W'(last_col_upd);
    assign lr_ext = CMP_W'(last_row_upd);
    assign w_ext  = (lc_ext >= fc_ext) ? (lc_ext - fc_ext + CMP_W'(1)) : '0;
    assign h_ext  = (lr_ext >= fr_ext) ? (lr_ext - fr_ext + CMP_W'(1)) : '0;

    always_comb
    begin
        rect = '0;
        if (seen_upd)
        begin
            rect.left_x      = fc_ext[POS_OUT_W-1:0];
            rect.bottom_y    = lr_ext[POS_OUT_W-1:0];
            rect.rect_width  = w_ext[SIZE_OUT_W-1:0];
            rect.rect_height = h_ext[SIZE_OUT_W-1:0];
            rect.is_blocking = blocking_upd;
        end
    end

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        first_col_next = first_col_reg;
        first_row_next = first_row_reg;
        last_col_next  = last_col_reg;
        last_row_next  = last_row_reg;
        seen_next      = seen_reg;
        blocking_next  = blocking_reg;
        if (step)
        begin
            if (tile_done)
            begin
                col_next       = '0;
                row_next       = '0;
                first_col_next = '0;
                first_row_next = '0;
                last_col_next  = '0;
                last_row_next  = '0;
                seen_next      = 1'b0;
                blocking_next  = 1'b1;
            end
            else
            begin
                first_col_next = first_col_upd;
                first_row_next = first_row_upd;
                last_col_next  = last_col_upd;
                last_row_next  = last_row_upd;
                seen_next      = seen_upd;
                blocking_next  = blocking_upd;
                if (row_end)
                begin
                    col_next = '0;
                    row_next = row_inc[POS_W-1:0];
                end
                else
                begin
                    col_next = col_inc[POS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            first_col_reg <= '0;
            first_row_reg <= '0;
            last_col_reg  <= '0;
            last_row_reg  <= '0;
            seen_reg      <= 1'b0;
            blocking_reg  <= 1'b1;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            first_col_reg <= first_col_next;
            first_row_reg <= first_row_next;
            last_col_reg  <= last_col_next;
            last_row_reg  <= last_row_next;
            seen_reg      <= seen_next;
            blocking_reg  <= blocking_next;
        end
    end

    // a finished tile leaves the scan state cleared
    a_clear_after_tile: assert property (@(posedge clk) disable iff (!rst_n)
        step && tile_done |=> col_reg == '0 && row_reg == '0 && !seen_reg && blocking_reg)
        else $error("scan state not cleared after tile");

    // positions stay below MAX_TILE
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(col_reg) < max_ext && CMP_W'(row_reg) < max_ext)
        else $error("scan position beyond tile");

    // the first marker row never comes after the last marker row
    a_first_not_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> first_row_reg <= last_row_reg)
        else $error("first marker row after last marker row");

endmodule

[rtl/core/tmrs_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmrs_out_stage
// result register: holds one rectangle until the consumer takes it
// ----------------------------------------------------------------------------
module tmrs_out_stage
    import tmrs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load,
    input  rect_t load_rect,
    output logic  slot_free,
    output logic  rect_valid,
    input  logic  rect_stall,
    output rect_t rect
);

    logic  valid_reg;
    logic  valid_next;
    rect_t rect_reg;

    assign slot_free = !valid_reg || !rect_stall;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (!rect_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            rect_reg <= load_rect;
    end

    assign rect_valid = valid_reg;
    assign rect       = rect_reg;

endmodule
